FILE: design/rmsa_pkg.sv
// Package for the root motion scale adapter.
// Shared constants, configuration register layout and register index codes.
// No dependencies.
`default_nettype none

package rmsa_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC            = 16;
  localparam int DT_W            = 24;
  localparam int SCALE_W         = 24;
  localparam int STAND_W         = 31;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = STAND_W;
  localparam int QUEUE_DEPTH     = 4;
  localparam int NEAR_ZERO_LSB   = 6;

  localparam logic [SCALE_W-1:0] ONE_Q16 = SCALE_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STAND_SPEED = 2'd0,
    CFG_MIN_SCALE   = 2'd1,
    CFG_MAX_SCALE   = 2'd2,
    CFG_SEPARATE    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [STAND_W-1:0] stand_speed;
    logic [SCALE_W-1:0] min_scale;
    logic [SCALE_W-1:0] max_scale;
    logic               separate;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    stand_speed: STAND_W'(6554),
    min_scale:   SCALE_W'(32768),
    max_scale:   SCALE_W'(131072),
    separate:    1'b0
  };

endpackage

`default_nettype wire

FILE: design/rmsa_if.sv
// Request and result channel interfaces for the root motion scale adapter.
// Depends on rmsa_pkg.
`default_nettype none

interface rmsa_in_if import rmsa_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic signed [CW-1:0]   authored_x;
  logic signed [CW-1:0]   authored_y;
  logic signed [CW-1:0]   authored_z;
  logic signed [CW-1:0]   desired_vx;
  logic signed [CW-1:0]   desired_vz;
  logic signed [DT_W-1:0] step_time;

  modport source (output valid, authored_x, authored_y, authored_z, desired_vx, desired_vz,
                  step_time, input ready);
  modport sink (input valid, authored_x, authored_y, authored_z, desired_vx, desired_vz,
                step_time, output ready);
endinterface

interface rmsa_out_if import rmsa_pkg::*; #(
  parameter int CW = COORD_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] out_x;
  logic signed [CW-1:0] out_y;
  logic signed [CW-1:0] out_z;
  logic [SCALE_W-1:0]   forward_scale;
  logic [SCALE_W-1:0]   lateral_scale;
  logic                 was_clamped;

  modport source (output valid, out_x, out_y, out_z, forward_scale, lateral_scale,
                  was_clamped, input ready);
  modport sink (input valid, out_x, out_y, out_z, forward_scale, lateral_scale,
                was_clamped, output ready);
endinterface

`default_nettype wire

FILE: design/rmsa_front.sv
// Front end: accepts requests, squares, speed test and wanted step.
// Three stages, stall as one block on a full queue. Depends on rmsa_pkg, rmsa_if.
`default_nettype none

module rmsa_front import rmsa_pkg::*; #(
  parameter int  CW   = COORD_WIDTH_DEF,
  parameter type fb_t = logic
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  rmsa_in_if.sink    motion,
  output logic       push_valid,
  input  wire logic  push_ready,
  output fb_t        push_data
);

  localparam int SW   = 2 * CW;
  localparam int PW   = CW + DT_W - 1;
  localparam int MW   = PW - FRAC;
  localparam int SSW  = 2 * STAND_W;
  localparam int CMPW = (SW > SSW) ? SW : SSW;
  localparam logic [MW-1:0] POS_LIM = MW'({1'b0, {(CW-1){1'b1}}});
  localparam logic [MW-1:0] NEG_LIM = MW'({1'b1, {(CW-1){1'b0}}});

  logic adv;
  logic v1, v2, v3;

  logic [CW-1:0]     mvx, mvz, max_a, maz_a;
  logic [DT_W-2:0]   dtm;
  logic              dtp;
  logic [SW-1:0]     vx2, vz2, ax2, az2;
  logic [PW-1:0]     wxp, wzp;
  logic [SSW-1:0]    stand_sq;

  logic signed [CW-1:0] s1_ax, s1_ay, s1_az;
  logic [SW-1:0]        s1_vx2, s1_vz2, s1_ax2, s1_az2;
  logic [PW-1:0]        s1_wxp, s1_wzp;
  logic                 s1_vxn, s1_vzn, s1_dtp;

  logic [SW-1:0]        sp;
  logic [MW-1:0]        wm_x, wm_z, lim_x, lim_z;
  logic [CW-1:0]        mwx, mwz;

  logic signed [CW-1:0] s2_ax, s2_ay, s2_az;
  logic                 s2_adapt, s2_wxn, s2_wzn;
  logic [CW-1:0]        s2_mwx, s2_mwz;
  logic [SW-1:0]        s2_hsum;

  logic signed [CW-1:0] s3_ax, s3_ay, s3_az;
  logic                 s3_adapt, s3_wxn, s3_wzn;
  logic [CW-1:0]        s3_mwx, s3_mwz;
  logic [SW-1:0]        s3_hsum, s3_wx2, s3_wz2;

  assign adv          = !v3 || push_ready;
  assign motion.ready = adv;
  assign push_valid   = v3;

  assign mvx   = motion.desired_vx[CW-1] ? CW'(-motion.desired_vx) : CW'(motion.desired_vx);
  assign mvz   = motion.desired_vz[CW-1] ? CW'(-motion.desired_vz) : CW'(motion.desired_vz);
  assign max_a = motion.authored_x[CW-1] ? CW'(-motion.authored_x) : CW'(motion.authored_x);
  assign maz_a = motion.authored_z[CW-1] ? CW'(-motion.authored_z) : CW'(motion.authored_z);
  assign dtm   = motion.step_time[DT_W-2:0];
  assign dtp   = !motion.step_time[DT_W-1] && (motion.step_time != '0);
  assign vx2   = mvx * mvx;
  assign vz2   = mvz * mvz;
  assign ax2   = max_a * max_a;
  assign az2   = maz_a * maz_a;
  assign wxp   = mvx * dtm;
  assign wzp   = mvz * dtm;

  // stage 2: speed test and saturated wanted step magnitudes
  assign sp    = s1_vx2 + s1_vz2;
  assign wm_x  = s1_wxp[PW-1:FRAC];
  assign wm_z  = s1_wzp[PW-1:FRAC];
  assign lim_x = s1_vxn ? NEG_LIM : POS_LIM;
  assign lim_z = s1_vzn ? NEG_LIM : POS_LIM;
  assign mwx   = (wm_x > lim_x) ? lim_x[CW-1:0] : wm_x[CW-1:0];
  assign mwz   = (wm_z > lim_z) ? lim_z[CW-1:0] : wm_z[CW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= motion.valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    stand_sq <= cfg.stand_speed * cfg.stand_speed;
    if (adv) begin
      s1_ax  <= motion.authored_x;
      s1_ay  <= motion.authored_y;
      s1_az  <= motion.authored_z;
      s1_vx2 <= vx2;
      s1_vz2 <= vz2;
      s1_ax2 <= ax2;
      s1_az2 <= az2;
      s1_wxp <= wxp;
      s1_wzp <= wzp;
      s1_vxn <= motion.desired_vx[CW-1];
      s1_vzn <= motion.desired_vz[CW-1];
      s1_dtp <= dtp;

      s2_ax    <= s1_ax;
      s2_ay    <= s1_ay;
      s2_az    <= s1_az;
      s2_adapt <= s1_dtp && (CMPW'(sp) >= CMPW'(stand_sq));
      s2_mwx   <= mwx;
      s2_mwz   <= mwz;
      s2_wxn   <= s1_vxn && (mwx != '0);
      s2_wzn   <= s1_vzn && (mwz != '0);
      s2_hsum  <= s1_ax2 + s1_az2;

      s3_ax    <= s2_ax;
      s3_ay    <= s2_ay;
      s3_az    <= s2_az;
      s3_adapt <= s2_adapt;
      s3_mwx   <= s2_mwx;
      s3_mwz   <= s2_mwz;
      s3_wxn   <= s2_wxn;
      s3_wzn   <= s2_wzn;
      s3_hsum  <= s2_hsum;
      s3_wx2   <= s2_mwx * s2_mwx;
      s3_wz2   <= s2_mwz * s2_mwz;
    end
  end

  always_comb begin
    push_data        = '0;
    push_data.adapt  = s3_adapt;
    push_data.ax     = s3_ax;
    push_data.ay     = s3_ay;
    push_data.az     = s3_az;
    push_data.hsum   = s3_hsum;
    push_data.wsum   = s3_wx2 + s3_wz2;
    push_data.mwx    = s3_mwx;
    push_data.mwz    = s3_mwz;
    push_data.wx_neg = s3_wxn;
    push_data.wz_neg = s3_wzn;
  end

endmodule

`default_nettype wire

FILE: design/rmsa_queue.sv
// Short queue between front and back end.
// Depends on rmsa_pkg.
`default_nettype none

module rmsa_queue import rmsa_pkg::*; #(
  parameter type fb_t  = logic,
  parameter int  DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire fb_t  push_data,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output fb_t       pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  fb_t            mem [DEPTH];
  logic [AW-1:0]  wr_ptr, rd_ptr;
  logic [AW:0]    count;
  logic           push, pop;

  assign push_ready = count != (AW+1)'(DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: design/rmsa_sqrt.sv
// Two-lane pipelined integer square root, one result bit per stage.
// Carries a sideband payload alongside. Depends on rmsa_pkg.
`default_nettype none

module rmsa_sqrt import rmsa_pkg::*; #(
  parameter int  CW     = COORD_WIDTH_DEF,
  parameter type side_t = logic
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire side_t                 in_side,
  input  wire logic [1:0][2*CW-1:0]  rad,
  output logic                       out_valid,
  output side_t                      out_side,
  output logic [1:0][CW-1:0]         root
);

  localparam int SW = 2 * CW;
  localparam int RW = CW + 2;
  localparam int NS = CW;

  logic [NS-1:0]  v;
  side_t          side_q   [NS];
  side_t          side_src [NS];
  logic [RW-1:0]  rem_q [NS][2], rem_src [NS][2], rem_n [NS][2];
  logic [CW-1:0]  rt_q  [NS][2], rt_src  [NS][2], rt_n  [NS][2];
  logic [SW-1:0]  rd_q  [NS][2], rd_src  [NS][2], rd_n  [NS][2];

  always_comb begin
    side_src[0] = in_side;
    for (int l = 0; l < 2; l++) begin
      rem_src[0][l] = '0;
      rt_src[0][l]  = '0;
      rd_src[0][l]  = rad[l];
    end
    for (int s = 1; s < NS; s++) begin
      side_src[s] = side_q[s-1];
      for (int l = 0; l < 2; l++) begin
        rem_src[s][l] = rem_q[s-1][l];
        rt_src[s][l]  = rt_q[s-1][l];
        rd_src[s][l]  = rd_q[s-1][l];
      end
    end
  end

  always_comb begin : step
    logic [RW-1:0] sh;
    logic [RW-1:0] tr;
    for (int s = 0; s < NS; s++) begin
      for (int l = 0; l < 2; l++) begin
        sh = {rem_src[s][l][RW-3:0], rd_src[s][l][SW-1 -: 2]};
        tr = {rt_src[s][l], 2'b01};
        if (sh >= tr) begin
          rem_n[s][l] = sh - tr;
          rt_n[s][l]  = {rt_src[s][l][CW-2:0], 1'b1};
        end else begin
          rem_n[s][l] = sh;
          rt_n[s][l]  = {rt_src[s][l][CW-2:0], 1'b0};
        end
        rd_n[s][l] = {rd_src[s][l][SW-3:0], 2'b00};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NS; s++) begin
        side_q[s] <= side_src[s];
        for (int l = 0; l < 2; l++) begin
          rem_q[s][l] <= rem_n[s][l];
          rt_q[s][l]  <= rt_n[s][l];
          rd_q[s][l]  <= rd_n[s][l];
        end
      end
    end
  end

  assign out_valid = v[NS-1];
  assign out_side  = side_q[NS-1];
  assign root[0]   = rt_q[NS-1][0];
  assign root[1]   = rt_q[NS-1][1];

endmodule

`default_nettype wire

FILE: design/rmsa_div.sv
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Numerator CW+16 bits, divisor CW bits; carries a sideband. Depends on rmsa_pkg.
`default_nettype none

module rmsa_div import rmsa_pkg::*; #(
  parameter int  CW     = COORD_WIDTH_DEF,
  parameter type side_t = logic
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire side_t                    in_side,
  input  wire logic [1:0][CW+FRAC-1:0]  num,
  input  wire logic [1:0][CW-1:0]       den,
  output logic                          out_valid,
  output side_t                         out_side,
  output logic [1:0][CW+FRAC-1:0]       quo
);

  localparam int QW = CW + FRAC;
  localparam int NS = QW;

  logic [NS-1:0]  v;
  side_t          side_q   [NS];
  side_t          side_src [NS];
  logic [CW-1:0]  r_q [NS][2], r_src [NS][2], r_n [NS][2];
  logic [QW-1:0]  n_q [NS][2], n_src [NS][2], n_n [NS][2];
  logic [CW-1:0]  d_q [NS][2], d_src [NS][2];

  always_comb begin
    side_src[0] = in_side;
    for (int l = 0; l < 2; l++) begin
      r_src[0][l] = '0;
      n_src[0][l] = num[l];
      d_src[0][l] = den[l];
    end
    for (int s = 1; s < NS; s++) begin
      side_src[s] = side_q[s-1];
      for (int l = 0; l < 2; l++) begin
        r_src[s][l] = r_q[s-1][l];
        n_src[s][l] = n_q[s-1][l];
        d_src[s][l] = d_q[s-1][l];
      end
    end
  end

  always_comb begin : step
    logic [CW:0] sh;
    logic [CW:0] dd;
    logic        ge;
    for (int s = 0; s < NS; s++) begin
      for (int l = 0; l < 2; l++) begin
        sh = {r_src[s][l], n_src[s][l][QW-1]};
        dd = {1'b0, d_src[s][l]};
        ge = sh >= dd;
        r_n[s][l] = ge ? CW'(sh - dd) : sh[CW-1:0];
        n_n[s][l] = {n_src[s][l][QW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NS; s++) begin
        side_q[s] <= side_src[s];
        for (int l = 0; l < 2; l++) begin
          r_q[s][l] <= r_n[s][l];
          n_q[s][l] <= n_n[s][l];
          d_q[s][l] <= d_src[s][l];
        end
      end
    end
  end

  assign out_valid = v[NS-1];
  assign out_side  = side_q[NS-1];
  assign quo[0]    = n_q[NS-1][0];
  assign quo[1]    = n_q[NS-1][1];

endmodule

`default_nettype wire

FILE: design/rmsa_back.sv
// Back end: magnitudes, ratio, clamp, scaling and the result register.
// Whole pipeline advances together. Depends on rmsa_pkg, rmsa_if, rmsa_sqrt, rmsa_div.
`default_nettype none

module rmsa_back import rmsa_pkg::*; #(
  parameter int  CW   = COORD_WIDTH_DEF,
  parameter type fb_t = logic
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  pop_valid,
  output logic       pop_ready,
  input  wire fb_t   pop_data,
  rmsa_out_if.source result
);

  localparam int SW  = 2 * CW;
  localparam int QW  = CW + FRAC;
  localparam int PW  = CW + SCALE_W;
  localparam int MW2 = PW - FRAC;
  localparam logic [MW2-1:0] HALF = MW2'({1'b1, {(CW-1){1'b0}}});
  localparam logic [MW2-1:0] PMAX = MW2'({1'b0, {(CW-1){1'b1}}});

  // lane 0 is forward (z, or joint), lane 1 is lateral (x)
  typedef struct packed {
    logic                 adapt;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] az;
    logic [CW-1:0]        mwx;
    logic [CW-1:0]        mwz;
    logic                 wxn;
    logic                 wzn;
  } sq_side_t;

  typedef struct packed {
    logic                 adapt;
    logic                 sep;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] az;
    logic [1:0]           neg;
    logic [1:0]           hz;
    logic [1:0]           big;
  } dv_side_t;

  function automatic logic [CW-1:0] sat_out(input logic neg, input logic [MW2-1:0] m);
    logic [CW-1:0] r;
    if (neg) begin
      r = (m >= HALF) ? {1'b1, {(CW-1){1'b0}}} : CW'(-m[CW-1:0]);
    end else begin
      r = (m > PMAX) ? {1'b0, {(CW-1){1'b1}}} : m[CW-1:0];
    end
    return r;
  endfunction

  logic adv, ov;

  sq_side_t               sq_in, sq_side;
  logic                   sq_v;
  logic [1:0][SW-1:0]     rad;
  logic [1:0][CW-1:0]     roots;

  dv_side_t               dv_in, dv_side;
  logic                   dv_v;
  logic [1:0][QW-1:0]     num;
  logic [1:0][CW-1:0]     den;
  logic [1:0][QW-1:0]     quo;
  logic [CW-1:0]          sel_max, sel_maz;
  logic [1:0][CW-1:0]     want;

  logic [1:0][SCALE_W-1:0] bnd;
  logic [1:0]              negc;
  logic [QW-1:0]           lo [2];

  logic                    c1_v, c1_adapt, c1_sep;
  logic signed [CW-1:0]    c1_ay;
  logic [CW-1:0]           c1_max, c1_maz;
  logic                    c1_axn, c1_azn;
  logic [1:0][SCALE_W-1:0] c1_b;
  logic [1:0][QW-1:0]      c1_q;
  logic [1:0]              c1_negc, c1_hz, c1_big;
  logic [SCALE_W-1:0]      c1_fs, c1_ls;
  logic [1:0]              flag;

  logic                    c2_v, c2_clamped, c2_axn, c2_azn;
  logic signed [CW-1:0]    c2_ay;
  logic [PW-1:0]           c2_px, c2_pz;
  logic [SCALE_W-1:0]      c2_fs, c2_ls;

  assign adv          = !ov || result.ready;
  assign pop_ready    = adv;
  assign result.valid = ov;

  always_comb begin
    sq_in       = '0;
    sq_in.adapt = pop_data.adapt;
    sq_in.ax    = pop_data.ax;
    sq_in.ay    = pop_data.ay;
    sq_in.az    = pop_data.az;
    sq_in.mwx   = pop_data.mwx;
    sq_in.mwz   = pop_data.mwz;
    sq_in.wxn   = pop_data.wx_neg;
    sq_in.wzn   = pop_data.wz_neg;
    rad[0]      = pop_data.hsum;
    rad[1]      = pop_data.wsum;
  end

  rmsa_sqrt #(
    .CW     (CW),
    .side_t (sq_side_t)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (pop_valid),
    .in_side   (sq_in),
    .rad       (rad),
    .out_valid (sq_v),
    .out_side  (sq_side),
    .root      (roots)
  );

  // operand select: roots[0] is have, roots[1] is need
  assign sel_max = sq_side.ax[CW-1] ? CW'(-sq_side.ax) : CW'(sq_side.ax);
  assign sel_maz = sq_side.az[CW-1] ? CW'(-sq_side.az) : CW'(sq_side.az);

  always_comb begin
    want[0] = cfg.separate ? sq_side.mwz : roots[1];
    den[0]  = cfg.separate ? sel_maz : roots[0];
    want[1] = sq_side.mwx;
    den[1]  = sel_max;
    dv_in        = '0;
    dv_in.adapt  = sq_side.adapt;
    dv_in.sep    = cfg.separate;
    dv_in.ax     = sq_side.ax;
    dv_in.ay     = sq_side.ay;
    dv_in.az     = sq_side.az;
    dv_in.neg[0] = cfg.separate && (sq_side.wzn != sq_side.az[CW-1]);
    dv_in.neg[1] = sq_side.wxn != sq_side.ax[CW-1];
    for (int l = 0; l < 2; l++) begin
      num[l]       = {want[l], {FRAC{1'b0}}};
      dv_in.hz[l]  = den[l] == '0;
      dv_in.big[l] = want[l] > CW'(NEAR_ZERO_LSB);
    end
  end

  rmsa_div #(
    .CW     (CW),
    .side_t (dv_side_t)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (sq_v),
    .in_side   (dv_in),
    .num       (num),
    .den       (den),
    .out_valid (dv_v),
    .out_side  (dv_side),
    .quo       (quo)
  );

  // clamp: raise to min, then lower to max; a negative ratio takes the lower of min and max
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      negc[l] = dv_side.neg[l] && (quo[l] != '0);
      lo[l]   = (QW'(cfg.min_scale) > quo[l]) ? QW'(cfg.min_scale) : quo[l];
      if (negc[l]) begin
        bnd[l] = (cfg.min_scale > cfg.max_scale) ? cfg.max_scale : cfg.min_scale;
      end else begin
        bnd[l] = (lo[l] > QW'(cfg.max_scale)) ? cfg.max_scale : lo[l][SCALE_W-1:0];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      if (c1_hz[l]) begin
        flag[l] = c1_big[l];
      end else if (c1_negc[l]) begin
        flag[l] = ((QW+1)'(c1_b[l]) + (QW+1)'(c1_q[l])) > (QW+1)'(NEAR_ZERO_LSB);
      end else if (QW'(c1_b[l]) >= c1_q[l]) begin
        flag[l] = (QW'(c1_b[l]) - c1_q[l]) > QW'(NEAR_ZERO_LSB);
      end else begin
        flag[l] = (c1_q[l] - QW'(c1_b[l])) > QW'(NEAR_ZERO_LSB);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_v <= 1'b0;
      c2_v <= 1'b0;
      ov   <= 1'b0;
    end else if (adv) begin
      c1_v <= dv_v;
      c2_v <= c1_v;
      ov   <= c2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_adapt <= dv_side.adapt;
      c1_sep   <= dv_side.sep;
      c1_ay    <= dv_side.ay;
      c1_max   <= dv_side.ax[CW-1] ? CW'(-dv_side.ax) : CW'(dv_side.ax);
      c1_maz   <= dv_side.az[CW-1] ? CW'(-dv_side.az) : CW'(dv_side.az);
      c1_axn   <= dv_side.ax[CW-1];
      c1_azn   <= dv_side.az[CW-1];
      c1_b     <= bnd;
      c1_q     <= quo;
      c1_negc  <= negc;
      c1_hz    <= dv_side.hz;
      c1_big   <= dv_side.big;
      c1_fs    <= (dv_side.adapt && !dv_side.hz[0]) ? bnd[0] : ONE_Q16;
      if (!dv_side.adapt) begin
        c1_ls <= ONE_Q16;
      end else if (dv_side.sep) begin
        c1_ls <= dv_side.hz[1] ? ONE_Q16 : bnd[1];
      end else begin
        c1_ls <= dv_side.hz[0] ? ONE_Q16 : bnd[0];
      end

      c2_px      <= c1_max * c1_ls;
      c2_pz      <= c1_maz * c1_fs;
      c2_axn     <= c1_axn;
      c2_azn     <= c1_azn;
      c2_ay      <= c1_ay;
      c2_fs      <= c1_fs;
      c2_ls      <= c1_ls;
      c2_clamped <= c1_adapt && (flag[0] || (c1_sep && flag[1]));

      result.out_x         <= sat_out(c2_axn, c2_px[PW-1:FRAC]);
      result.out_y         <= c2_ay;
      result.out_z         <= sat_out(c2_azn, c2_pz[PW-1:FRAC]);
      result.forward_scale <= c2_fs;
      result.lateral_scale <= c2_ls;
      result.was_clamped   <= c2_clamped;
    end
  end

`ifndef SYNTHESIS
  a_pass_unit: assert property (@(posedge clk) disable iff (rst)
    c1_v && !c1_adapt |-> c1_fs == ONE_Q16 && c1_ls == ONE_Q16)
    else $error("pass-through item carries a scale other than one");

  a_joint_same: assert property (@(posedge clk) disable iff (rst)
    c1_v && c1_adapt && !c1_sep |-> c1_fs == c1_ls)
    else $error("joint mode scales differ");

  a_bounds: assert property (@(posedge clk) disable iff (rst)
    c1_v && c1_adapt && !c1_hz[0] && cfg.min_scale <= cfg.max_scale
      |-> c1_fs >= cfg.min_scale && c1_fs <= cfg.max_scale)
    else $error("forward scale outside configured bounds");
`endif

endmodule

`default_nettype wire

FILE: design/root_motion_scale_adapt_top.sv
// A request reaches the result through the front end, the queue, the square root
// (one bit per stage), the divider (one bit per stage) and the back end.
// Throughput: one request per cycle unless the result side stalls; the result register and
// queue let the sides stall independently.
// Reset: synchronous; configuration returns to defaults, pipeline and queue empty.
// Depends on rmsa_pkg, rmsa_if, rmsa_front, rmsa_queue, rmsa_back.
`default_nettype none

module root_motion_scale_adapt_top import rmsa_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  rmsa_in_if.sink                    motion,
  rmsa_out_if.source                 result
);

  localparam int CW = COORD_WIDTH;

  typedef struct packed {
    logic                 adapt;
    logic signed [CW-1:0] ax;
    logic signed [CW-1:0] ay;
    logic signed [CW-1:0] az;
    logic [2*CW-1:0]      hsum;
    logic [2*CW-1:0]      wsum;
    logic [CW-1:0]        mwx;
    logic [CW-1:0]        mwz;
    logic                 wx_neg;
    logic                 wz_neg;
  } fb_t;

  cfg_t cfg;
  logic push_valid, push_ready, pop_valid, pop_ready;
  fb_t  push_data, pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_STAND_SPEED: cfg.stand_speed <= cfg_data[STAND_W-1:0];
        CFG_MIN_SCALE:   cfg.min_scale   <= cfg_data[SCALE_W-1:0];
        CFG_MAX_SCALE:   cfg.max_scale   <= cfg_data[SCALE_W-1:0];
        CFG_SEPARATE:    cfg.separate    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rmsa_front #(
    .CW   (CW),
    .fb_t (fb_t)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .motion     (motion),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  rmsa_queue #(
    .fb_t  (fb_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  rmsa_back #(
    .CW   (CW),
    .fb_t (fb_t)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .result    (result)
  );

endmodule

`default_nettype wire
